[hdl/tridiagonal_thomas_solver_core_macros.svh]
// Assertion macros for the tridiagonal solver core.
// Used by the top level; no other dependencies.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_CORE_MACROS_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_CORE_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tts_pkg.sv]
// Shared types, constants and helpers for the tridiagonal solver core.
// No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

	localparam int TTS_MAX_ROWS  = 64;
	localparam int TTS_FRAC_BITS = 16;
	localparam int TTS_WORD_W    = 32;
	localparam int TTS_IDX_W     = 6;
	localparam int TTS_IN_W      = 128;
	localparam int TTS_OUT_W     = 40;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_SUP,
		ST_MUL_RHS,
		ST_SUB,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ROW_END,
		ST_BS_READ,
		ST_BS_MUL,
		ST_BS_SUB,
		ST_BS_OUT,
		ST_ERR_OUT
	} tts_state_t;

	typedef struct packed {
		logic capture;
		logic mul_super;
		logic mul_rhs;
		logic sub_rhs;
		logic div_start;
		logic flag_error;
		logic commit;
		logic row_end;
		logic bs_load;
		logic bs_mul;
		logic bs_sub;
		logic emit;
		logic emit_error;
	} tts_cmd_t;

	typedef struct packed {
		logic row_first;
		logic row_skip;
		logic piv_zero;
		logic div_done;
		logic last_row;
		logic error_seen;
		logic bs_first;
		logic bs_idx_zero;
		logic out_free;
	} tts_sts_t;

	typedef struct packed {
		logic                  sat;
		logic [TTS_WORD_W-1:0] value;
	} tts_clip_t;

	function automatic tts_clip_t tts_clip(input logic signed [63:0] v);
		tts_clip_t r;
		if (v > 64'sd2147483647) begin
			r.sat   = 1'b1;
			r.value = 32'h7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r.sat   = 1'b1;
			r.value = 32'h8000_0000;
		end else begin
			r.sat   = 1'b0;
			r.value = v[TTS_WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/tts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/tts_div.sv]
// Radix-2 signed fixed-point divider, one quotient bit per cycle, saturating.
// Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_div #(
	parameter int FRAC_BITS = tts_pkg::TTS_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tts_pkg::TTS_WORD_W-1:0] num,
	input  logic signed [tts_pkg::TTS_WORD_W-1:0] den,
	output logic                                done,
	output logic signed [tts_pkg::TTS_WORD_W-1:0] quo,
	output logic                                sat
);

	import tts_pkg::*;

	localparam int W = TTS_WORD_W;

	logic [W-1:0]   un;
	logic [W-1:0]   ud;
	logic [W-1:0]   dhi;
	logic [W:0]     trial;
	logic           fits;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   q_q;
	logic [W-1:0]   ud_q;
	logic           neg_q;
	logic           ovf_q;
	logic           busy_q;
	logic           done_q;
	logic [4:0]     cnt_q;

	assign un  = num[W-1] ? (~num + 1'b1) : num;
	assign ud  = den[W-1] ? (~den + 1'b1) : den;
	assign dhi = un >> (W - FRAC_BITS);

	assign trial = {rem_q, q_q[W-1]};
	assign fits  = trial >= {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dhi;
			q_q   <= un << FRAC_BITS;
			ud_q  <= ud;
			neg_q <= num[W-1] ^ den[W-1];
			ovf_q <= dhi >= ud;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, ud_q}) : trial[W-1:0];
			q_q   <= {q_q[W-2:0], fits};
		end
	end

	always_comb begin
		sat = 1'b0;
		quo = q_q;
		if (neg_q) begin
			if (ovf_q || (q_q[W-1] && (q_q[W-2:0] != '0))) begin
				sat = 1'b1;
				quo = {1'b1, {(W-1){1'b0}}};
			end else begin
				quo = ~q_q + 1'b1;
			end
		end else if (ovf_q || q_q[W-1]) begin
			sat = 1'b1;
			quo = {1'b0, {(W-1){1'b1}}};
		end
	end

	assign done = done_q;

endmodule

[hdl/tts_datapath.sv]
// Datapath: row registers, shared multiplier and saturating subtractor,
// two dividers, coefficient RAMs and the result register. Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_datapath #(
	parameter int MAX_ROWS  = tts_pkg::TTS_MAX_ROWS,
	parameter int FRAC_BITS = tts_pkg::TTS_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tts_pkg::tts_cmd_t               cmd,
	output tts_pkg::tts_sts_t               sts,
	input  logic [tts_pkg::TTS_IN_W-1:0]    in_data,
	input  logic                            in_last,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [tts_pkg::TTS_OUT_W-1:0]   m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast
);

	import tts_pkg::*;

	localparam int W  = TTS_WORD_W;
	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam logic [CW-1:0] ROW_LIMIT = CW'(MAX_ROWS);
	localparam logic [AW-1:0] TOP_IDX   = AW'(MAX_ROWS - 1);
	localparam logic signed [63:0] RND  = 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [W-1:0]  a_q, b_q, c_q, d_q;
	logic                 last_q;
	logic signed [W-1:0]  prev_super_q, prev_rhs_q;
	logic signed [W-1:0]  piv_q, num_q, x_q;
	logic signed [63:0]   prod_q;
	logic [CW-1:0]        row_count_q;
	logic                 error_q, sat_q;
	logic [AW-1:0]        bs_idx_q;
	logic                 bs_first_q;
	logic                 out_valid_q;
	logic [TTS_IDX_W-1:0] out_idx_q;
	logic [W-1:0]         out_sol_q;
	logic                 out_sat_q, out_err_q, out_last_q;

	logic signed [W-1:0]  ms_rd, mr_rd;
	logic signed [W-1:0]  mul_x, mul_y;
	logic signed [W-1:0]  sub_base;
	logic signed [63:0]   rnd_prod, diff;
	tts_clip_t            clip_r;
	logic                 div_start;
	logic                 done_sup, done_rhs;
	logic signed [W-1:0]  q_sup, q_rhs;
	logic                 sat_sup, sat_rhs;
	logic                 row_full;
	logic                 out_free;
	logic                 sys_clear;

	assign row_full  = row_count_q >= ROW_LIMIT;
	assign out_free  = !out_valid_q || m_tready;
	assign div_start = cmd.div_start;
	assign sys_clear = cmd.emit_error || (cmd.emit && (bs_idx_q == '0));

	assign mul_x    = cmd.bs_mul ? ms_rd : a_q;
	assign mul_y    = cmd.mul_super ? prev_super_q : (cmd.mul_rhs ? prev_rhs_q : x_q);
	assign sub_base = cmd.mul_rhs ? b_q : (cmd.sub_rhs ? d_q : mr_rd);
	assign rnd_prod = (prod_q + RND) >>> FRAC_BITS;
	assign diff     = 64'(sub_base) - rnd_prod;
	assign clip_r   = tts_clip(diff);

	tts_div #(.FRAC_BITS(FRAC_BITS)) u_div_sup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (c_q),
		.den    (piv_q),
		.done   (done_sup),
		.quo    (q_sup),
		.sat    (sat_sup)
	);

	tts_div #(.FRAC_BITS(FRAC_BITS)) u_div_rhs (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (piv_q),
		.done   (done_rhs),
		.quo    (q_rhs),
		.sat    (sat_rhs)
	);

	tts_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_ram_super (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (row_count_q[AW-1:0]),
		.wdata (q_sup),
		.raddr (bs_idx_q),
		.rdata (ms_rd)
	);

	tts_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_ram_rhs (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (row_count_q[AW-1:0]),
		.wdata (q_rhs),
		.raddr (bs_idx_q),
		.rdata (mr_rd)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_q   <= in_data[W-1:0];
			b_q   <= in_data[2*W-1:W];
			c_q   <= in_data[3*W-1:2*W];
			d_q   <= in_data[4*W-1:3*W];
			piv_q <= in_data[2*W-1:W];
			num_q <= in_data[4*W-1:3*W];
		end
		if (cmd.mul_super || cmd.mul_rhs || cmd.bs_mul) begin
			prod_q <= 64'(mul_x) * 64'(mul_y);
		end
		if (cmd.mul_rhs) begin
			piv_q <= clip_r.value;
		end
		if (cmd.sub_rhs) begin
			num_q <= clip_r.value;
		end
		if (cmd.commit) begin
			prev_super_q <= q_sup;
			prev_rhs_q   <= q_rhs;
		end
		if (cmd.bs_load) begin
			x_q <= mr_rd;
		end
		if (cmd.bs_sub) begin
			x_q <= clip_r.value;
		end
		if (cmd.emit) begin
			out_idx_q  <= TTS_IDX_W'(bs_idx_q);
			out_sol_q  <= x_q;
			out_sat_q  <= sat_q;
			out_err_q  <= 1'b0;
			out_last_q <= bs_idx_q == '0;
		end
		if (cmd.emit_error) begin
			out_idx_q  <= '0;
			out_sol_q  <= '0;
			out_sat_q  <= 1'b0;
			out_err_q  <= 1'b1;
			out_last_q <= 1'b1;
		end
		if (cmd.row_end) begin
			bs_idx_q <= row_full ? TOP_IDX : row_count_q[AW-1:0];
		end else if (cmd.emit && (bs_idx_q != '0)) begin
			bs_idx_q <= bs_idx_q - 1'b1;
		end
	end

	// system control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			row_count_q <= '0;
			error_q     <= 1'b0;
			sat_q       <= 1'b0;
			bs_first_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				last_q <= in_last;
			end
			if (cmd.emit || cmd.emit_error) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.row_end) begin
				bs_first_q <= 1'b1;
			end else if (cmd.emit) begin
				bs_first_q <= 1'b0;
			end
			if (sys_clear) begin
				row_count_q <= '0;
				error_q     <= 1'b0;
				sat_q       <= 1'b0;
			end else begin
				if (cmd.row_end && !row_full) begin
					row_count_q <= row_count_q + 1'b1;
				end
				if (cmd.flag_error) begin
					error_q <= 1'b1;
				end
				if ((cmd.mul_rhs || cmd.sub_rhs || cmd.bs_sub) && clip_r.sat) begin
					sat_q <= 1'b1;
				end
				if (cmd.commit && (sat_sup || sat_rhs)) begin
					sat_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		sts.row_first   = row_count_q == '0;
		sts.row_skip    = row_full || error_q;
		sts.piv_zero    = piv_q == '0;
		sts.div_done    = done_sup && done_rhs;
		sts.last_row    = last_q;
		sts.error_seen  = error_q;
		sts.bs_first    = bs_first_q;
		sts.bs_idx_zero = bs_idx_q == '0;
		sts.out_free    = out_free;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_sat_q, out_sol_q, out_idx_q};
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

endmodule

[hdl/tts_ctrl.sv]
// Controller state machine sequencing forward sweep and back substitution.
// Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tts_pkg::tts_sts_t sts,
	output tts_pkg::tts_cmd_t cmd
);

	import tts_pkg::*;

	tts_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					if (sts.row_skip) begin
						state_d = ST_ROW_END;
					end else if (sts.row_first) begin
						state_d = ST_DIV_GO;
					end else begin
						state_d = ST_MUL_SUP;
					end
				end
			end
			ST_MUL_SUP: begin
				cmd.mul_super = 1'b1;
				state_d = ST_MUL_RHS;
			end
			ST_MUL_RHS: begin
				cmd.mul_rhs = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub_rhs = 1'b1;
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				if (sts.piv_zero) begin
					cmd.flag_error = 1'b1;
					state_d = ST_ROW_END;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.commit = 1'b1;
					state_d = ST_ROW_END;
				end
			end
			ST_ROW_END: begin
				cmd.row_end = 1'b1;
				if (!sts.last_row) begin
					state_d = ST_IDLE;
				end else if (sts.error_seen) begin
					state_d = ST_ERR_OUT;
				end else begin
					state_d = ST_BS_READ;
				end
			end
			ST_BS_READ: begin
				state_d = ST_BS_MUL;
			end
			ST_BS_MUL: begin
				if (sts.bs_first) begin
					cmd.bs_load = 1'b1;
					state_d = ST_BS_OUT;
				end else begin
					cmd.bs_mul = 1'b1;
					state_d = ST_BS_SUB;
				end
			end
			ST_BS_SUB: begin
				cmd.bs_sub = 1'b1;
				state_d = ST_BS_OUT;
			end
			ST_BS_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = sts.bs_idx_zero ? ST_IDLE : ST_BS_READ;
				end
			end
			ST_ERR_OUT: begin
				if (sts.out_free) begin
					cmd.emit_error = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/tridiagonal_thomas_solver_core.sv]
// Tridiagonal solver core: accepts one matrix row per input transfer and runs the
// Thomas algorithm in signed saturating fixed point. A full row passes through accept,
// two multiplies and subtracts through the shared multiplier, a pivot check that starts
// the dividers, the two radix-2 dividers (super-diagonal and right-hand side, run side
// by side, committing as they finish) and row end. The first row skips the multiplies;
// rows past MAX_ROWS or after a zero pivot go straight to row end. After the last row,
// back substitution reads the coefficient RAMs and emits one result per unknown while
// the output is free, highest unknown first; a zero pivot yields a single error result
// instead. The result register lets the next system's rows be accepted while the final
// result waits.
// Depends on tts_pkg, tts_ctrl, tts_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "tridiagonal_thomas_solver_core_macros.svh"

module tridiagonal_thomas_solver_core #(
	parameter int MAX_ROWS  = tts_pkg::TTS_MAX_ROWS,
	parameter int FRAC_BITS = tts_pkg::TTS_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sub_diag[31:0], main_diag[63:32], super_diag[95:64], rhs[127:96]
	input  logic [tts_pkg::TTS_IN_W-1:0]  s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// unknown_index[5:0], solution[37:6], saturated[38], zero pad[39]
	output logic [tts_pkg::TTS_OUT_W-1:0] m_tdata,
	// pivot_error[0]
	output logic                          m_tuser,
	output logic                          m_tlast
);

	import tts_pkg::*;

	tts_cmd_t cmd;
	tts_sts_t sts;

	tts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tts_datapath #(
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.in_last  (s_tlast),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`TTS_ASSERT_IMP(a_err_form, clk, arst_n, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "error result not a lone zero result")
	`TTS_ASSERT_IMP(a_last_idx, clk, arst_n, m_tvalid && m_tlast && !m_tuser, m_tdata[5:0] == '0, "final result not for unknown zero")
	`TTS_ASSERT_IMP(a_mid_idx, clk, arst_n, m_tvalid && !m_tlast, (m_tdata[5:0] != '0) && !m_tuser, "unknown zero or error result not marked last")
	`TTS_ASSERT_NXT(a_step_down, clk, arst_n, m_tvalid && m_tready && !m_tlast && s_tready, 1'b0, "input taken during back substitution")

endmodule

[dv/tts_solution_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the tridiagonal solver core: watches both stream channels, solves
// each system in saturating fixed point and compares every result transfer.
// Depends on tts_pkg.

module tts_solution_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [tts_pkg::TTS_IN_W-1:0]  s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [tts_pkg::TTS_OUT_W-1:0] m_tdata,
	input  logic                          m_tuser,
	input  logic                          m_tlast,
	output int                            fail_count,
	output int                            pending,
	output int                            checked
);
	import tts_pkg::*;

	localparam int FB = TTS_FRAC_BITS;

	typedef struct packed {
		logic [TTS_IDX_W-1:0]  idx;
		logic [TTS_WORD_W-1:0] value;
		logic                  sat;
		logic                  perr;
		logic                  lst;
	} solved_t;

	solved_t            solved_q[$];
	logic signed [31:0] cprime [TTS_MAX_ROWS];
	logic signed [31:0] dprime [TTS_MAX_ROWS];
	int                 rows_seen;
	bit                 pivot_fail;
	bit                 clipped;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			clipped = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] fx_mul(input logic signed [31:0] x,
		input logic signed [31:0] y);
		logic signed [63:0] p;
		p = 64'(x) * 64'(y);
		return (p + (64'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic logic signed [31:0] fx_div(input logic signed [31:0] num,
		input logic signed [31:0] den);
		logic signed [63:0] wn;
		logic signed [63:0] wd;
		logic [63:0]        q;
		logic [63:0]        nq;
		wn = num;
		wd = den;
		if (wn < 0) wn = -wn;
		if (wd < 0) wd = -wd;
		q = ($unsigned(wn) << FB) / $unsigned(wd);
		if (num[31] != den[31]) begin
			if (q > 64'h8000_0000) begin
				clipped = 1'b1;
				return 32'sh8000_0000;
			end
			nq = -q;
			return nq[31:0];
		end
		if (q > 64'h7fff_ffff) begin
			clipped = 1'b1;
			return 32'sh7fff_ffff;
		end
		return q[31:0];
	endfunction

	task automatic take_row(input logic signed [31:0] a, input logic signed [31:0] b,
		input logic signed [31:0] c, input logic signed [31:0] d, input bit lst);
		logic signed [31:0] piv;
		logic signed [31:0] num;
		logic signed [31:0] x;
		solved_t            r;
		int                 n;
		int                 k;
		int                 idx;
		if (rows_seen < TTS_MAX_ROWS) begin
			if (!pivot_fail) begin
				if (rows_seen == 0) begin
					piv = b;
					num = d;
				end else begin
					piv = sat32(b - fx_mul(a, cprime[rows_seen - 1]));
					num = sat32(d - fx_mul(a, dprime[rows_seen - 1]));
				end
				if (piv == 0) begin
					pivot_fail = 1'b1;
				end else begin
					cprime[rows_seen] = fx_div(c, piv);
					dprime[rows_seen] = fx_div(num, piv);
				end
			end
			rows_seen++;
		end
		if (!lst) return;
		if (pivot_fail) begin
			r = '0;
			r.perr = 1'b1;
			r.lst = 1'b1;
			solved_q.push_back(r);
		end else begin
			n = rows_seen;
			x = '0;
			for (k = 0; k < n; k++) begin
				idx = n - 1 - k;
				if (k == 0) x = dprime[idx];
				else x = sat32(dprime[idx] - fx_mul(cprime[idx], x));
				r.idx = idx[TTS_IDX_W-1:0];
				r.value = x;
				r.sat = clipped;
				r.perr = 1'b0;
				r.lst = (idx == 0);
				solved_q.push_back(r);
			end
		end
		rows_seen = 0;
		pivot_fail = 1'b0;
		clipped = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		solved_t got;
		solved_t want;
		if (!arst_n) begin
			solved_q.delete();
			rows_seen = 0;
			pivot_fail = 1'b0;
			clipped = 1'b0;
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (s_tvalid && s_tready)
				take_row(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96],
					s_tlast);
			if (m_tvalid && m_tready) begin
				got.idx = m_tdata[5:0];
				got.value = m_tdata[37:6];
				got.sat = m_tdata[38];
				got.perr = m_tuser;
				got.lst = m_tlast;
				if (solved_q.size() == 0) begin
					$error("result transfer with nothing pending: unknown_index %0d solution %h",
						got.idx, got.value);
					fail_count++;
				end else begin
					want = solved_q.pop_front();
					checked++;
					if (got.idx !== want.idx) begin
						$error("unknown_index: expected %0d, actual %0d", want.idx, got.idx);
						fail_count++;
					end
					if (got.value !== want.value) begin
						$error("solution: expected %h, actual %h", want.value, got.value);
						fail_count++;
					end
					if (got.sat !== want.sat) begin
						$error("saturated: expected %b, actual %b", want.sat, got.sat);
						fail_count++;
					end
					if (got.perr !== want.perr) begin
						$error("pivot_error: expected %b, actual %b", want.perr, got.perr);
						fail_count++;
					end
					if (got.lst !== want.lst) begin
						$error("last: expected %b, actual %b", want.lst, got.lst);
						fail_count++;
					end
				end
			end
			pending = solved_q.size();
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the tridiagonal solver core: clock, reset, row stimulus,
// result back-pressure, watchdog and verdict. Depends on tts_pkg, the core
// and tts_solution_checker.

module tb;
	import tts_pkg::*;

	localparam int HOLD_CYCLES = 800;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_ROWS = 90;
	localparam int LONG_ROWS   = TTS_MAX_ROWS + 2;

	typedef enum logic [1:0] {SYS_DOMINANT, SYS_NOISE, SYS_ZERO_PIVOT} sys_kind_t;

	typedef struct packed {
		logic [31:0] d;
		logic [31:0] c;
		logic [31:0] b;
		logic [31:0] a;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TTS_IN_W-1:0]  s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TTS_OUT_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	int                   fail_count;
	int                   pending;
	int                   checked;
	int                   rows_sent;
	int                   systems_sent;
	bit                   hold_req;
	bit                   hold_done;

	tridiagonal_thomas_solver_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	tts_solution_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic row_t mk(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		row_t r;
		r.a = a;
		r.b = b;
		r.c = c;
		r.d = d;
		return r;
	endfunction

	function automatic logic [31:0] coef_pm(input int unsigned span);
		logic [31:0] v;
		v = $urandom_range(0, 2 * span);
		return v - span;
	endfunction

	function automatic row_t make_row(input sys_kind_t kind, input bit zero_here);
		row_t        r;
		logic [31:0] mag;
		if (kind == SYS_NOISE) begin
			r = {$urandom, $urandom, $urandom, $urandom};
			return r;
		end
		mag = $urandom_range(2 * 65536, 8 * 65536);
		r.a = coef_pm(65536);
		r.b = $urandom_range(0, 1) ? -mag : mag;
		r.c = coef_pm(65536);
		r.d = coef_pm(1 << 23);
		if (zero_here) begin
			r.a = '0;
			r.b = '0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	task automatic send_row(input row_t r, input bit lst);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = r;
		s_tlast = lst;
		do @(posedge clk); while (!s_tready);
		rows_sent++;
		if (lst) systems_sent++;
	endtask

	task automatic send_system(input sys_kind_t kind, input int len);
		int zp;
		int i;
		zp = $urandom_range(0, len - 1);
		for (i = 0; i < len; i++)
			send_row(make_row(kind, kind == SYS_ZERO_PIVOT && i == zp), i == len - 1);
	endtask

	// hold off the sender until every pending result has been taken
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		int        start_rows;
		int        roll;
		bit        long_done;
		sys_kind_t kind;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		hold_req = 1'b0;
		rows_sent = 0;
		systems_sent = 0;
		long_done = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single row, sub-diagonal at its max is ignored
		send_row(mk(32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000, 32'h0002_8000), 1'b1);
		send_row(mk(32'h0000_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000), 1'b0);
		send_row(mk(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000), 1'b0);
		send_row(mk(32'h0001_0000, 32'h0004_0000, 32'h0000_0000, 32'h0003_0000), 1'b1);
		// divide overflow
		send_row(mk(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff), 1'b1);
		send_row(mk(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000), 1'b0);
		send_row(mk(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff), 1'b1);
		// zero pivot on the first row, then after elimination, then a lone zero row
		send_row(mk(32'h0000_0005, 32'h0000_0000, 32'h0000_0003, 32'h0000_0007), 1'b0);
		send_row(mk(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0001_0000), 1'b1);
		send_row(mk(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 1'b0);
		send_row(mk(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000), 1'b0);
		send_row(mk(32'h0000_8000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000), 1'b1);
		send_row(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000), 1'b1);
		send_row(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 1'b0);
		send_row(mk(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000), 1'b1);
		// overflow only in back substitution
		send_row(mk(32'h0000_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
		send_row(mk(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h7fff_ffff), 1'b1);
		drain();

		// long receiver hold-off starts with the first random system
		hold_req = 1'b1;
		start_rows = rows_sent;
		send_system(SYS_DOMINANT, 5);
		while (rows_sent - start_rows < RANDOM_ROWS) begin
			roll = $urandom_range(0, 99);
			kind = roll < 65 ? SYS_DOMINANT : roll < 85 ? SYS_NOISE : SYS_ZERO_PIVOT;
			if (!long_done && rows_sent - start_rows >= 20) begin
				send_system(SYS_DOMINANT, LONG_ROWS);
				long_done = 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				send_system(kind, $urandom_range(7, 12));
			end else begin
				send_system(kind, $urandom_range(1, 6));
			end
			if ($urandom_range(0, 9) == 0) drain();
		end
		drain();
		repeat (60) @(posedge clk);

		$display("Sent %0d rows in %0d systems, one of them past %0d rows; %0d results checked.",
			rows_sent, systems_sent, TTS_MAX_ROWS, checked);
		$display("Covered zero pivots, divide and back-substitution overflow, noise rows, stalls.");
		if (fail_count == 0) begin
			$display("tridiagonal_thomas_solver_core test passed");
		end else begin
			$display("tridiagonal_thomas_solver_core test failed");
		end
		$finish;
	end

	initial begin : receiver
		int run;
		int roll;
		m_tready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					m_tready = 1'b0;
					run = roll < 5 ? $urandom_range(10, 40) : $urandom_range(1, 3);
				end else begin
					m_tready = 1'b1;
					run = $urandom_range(1, 20);
				end
				repeat (run) @(negedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
			else idle++;
		end
		$display("tridiagonal_thomas_solver_core test failed");
		$finish;
	end

endmodule
